@@ sv/blps_pkg.sv @@
// shared constants, types and request codes of the bounded list
package blps_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned REQ_W    = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_BACK  = 2'd0,
    REQ_PUSH_FRONT = 2'd1,
    REQ_SEARCH     = 2'd2
  } req_e;

  typedef struct packed {
    logic shift;
    logic load;
    logic search;
  } cell_ctl_t;

endpackage

@@ sv/blps_if.sv @@
// request and response channel interfaces
interface blps_req_if
  import blps_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [REQ_W-1:0]         req_type;
  logic signed [WORD_W-1:0] value;

  modport source (output valid, req_type, value, input ready);
  modport sink   (input valid, req_type, value, output ready);
endinterface

interface blps_rsp_if
  import blps_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             found;
  logic [IDX_W-1:0] match_index;
  logic [CNT_W-1:0] entry_count;
  logic             push_rejected;
  logic             is_empty;
  logic             is_full;

  modport source (output valid, found, match_index, entry_count, push_rejected, is_empty,
                  is_full, input ready);
  modport sink   (input valid, found, match_index, entry_count, push_rejected, is_empty,
                  is_full, output ready);
endinterface

@@ sv/blps_cell.sv @@
// one list cell: holds a word, shifts from its neighbour and compares
module blps_cell
  import blps_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cell_ctl_t         ctl_i,
  input  logic              live_i,
  input  logic [WORD_W-1:0] prev_i,
  input  logic [WORD_W-1:0] word_i,
  output logic [WORD_W-1:0] entry_o,
  output logic              match_o
);

  logic [WORD_W-1:0] entry_q, entry_d;
  logic              match_q, match_d;

  always_comb begin
    entry_d = entry_q;
    if (ctl_i.shift) begin
      entry_d = prev_i;
    end else if (ctl_i.load) begin
      entry_d = word_i;
    end
  end

  // match flag is taken with each request and held until the next one
  assign match_d = ctl_i.search ? (live_i & (entry_q == word_i)) : match_q;

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else begin
      match_q <= match_d;
    end
  end

  assign entry_o = entry_q;
  assign match_o = match_q;

endmodule

@@ sv/blps_prio.sv @@
// lowest-position match encoder over the cell match flags
module blps_prio
  import blps_pkg::*;
(
  input  logic [CAPACITY-1:0] match_i,
  output logic                found_o,
  output logic [IDX_W-1:0]    index_o
);

  always_comb begin
    index_o = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (match_i[i]) begin
        index_o = IDX_W'(i);
      end
    end
  end

  assign found_o = |match_i;

endmodule

@@ sv/bounded_list_push_and_search.sv @@
// top level: bounded list as a row of cells with push and search
//
//  channel | dir | words carried
//  req_i   | in  | req_type, value
//  rsp_o   | out | found, match_index, entry_count, push_rejected, is_empty, is_full
//
// a request is taken into the cell row (a shift or compare in every cell at once, or a load
// into the first free cell) and each cell registers its match flag; the first match is then
// encoded into the output register, which holds the response while it is stalled.
// a new request is taken every cycle while the output register drains.
// reset empties the list at once; stored words hold no reset value.
// a stalled response holds the output register and, behind it, the request.
module bounded_list_push_and_search
  import blps_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  blps_req_if.sink    req_i,
  blps_rsp_if.source  rsp_o
);

  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              pend_q, pend_d;
  logic              rej_q, rej_d;
  logic              out_valid_q, out_valid_d;
  logic              found_q;
  logic [IDX_W-1:0]  index_q;
  logic [CNT_W-1:0]  count_q;
  logic              rej_out_q;

  logic              accept, retire, full, is_push, do_push;
  logic              is_back, is_front, is_search;
  logic [WORD_W-1:0] word;
  logic [WORD_W-1:0] entries [CAPACITY];
  logic [CAPACITY-1:0] match;
  logic              enc_found;
  logic [IDX_W-1:0]  enc_index;

  assign word      = req_i.value;
  assign full      = (cnt_q == CNT_W'(CAPACITY));
  assign is_back   = (req_i.req_type == REQ_PUSH_BACK);
  assign is_front  = (req_i.req_type == REQ_PUSH_FRONT);
  assign is_search = (req_i.req_type == REQ_SEARCH);
  assign is_push   = is_back | is_front;
  assign do_push   = accept & is_push & ~full;

  assign retire       = pend_q & (~out_valid_q | rsp_o.ready);
  assign req_i.ready  = ~pend_q | retire;
  assign accept       = req_i.valid & req_i.ready;

  // cell row
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    cell_ctl_t        ctl;
    logic [WORD_W-1:0] prev;

    assign ctl.shift  = do_push & is_front;
    assign ctl.load   = do_push & is_back & (cnt_q == CNT_W'(g));
    assign ctl.search = accept;

    if (g == 0) begin : g_head
      assign prev = word;
    end else begin : g_body
      assign prev = entries[g-1];
    end

    blps_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl),
      .live_i  ((CNT_W'(g) < cnt_q) & is_search),
      .prev_i  (prev),
      .word_i  (word),
      .entry_o (entries[g]),
      .match_o (match[g])
    );
  end

  blps_prio u_prio (
    .match_i (match),
    .found_o (enc_found),
    .index_o (enc_index)
  );

  // request control
  always_comb begin
    cnt_d  = cnt_q;
    pend_d = pend_q;
    rej_d  = rej_q;
    if (retire) begin
      pend_d = 1'b0;
    end
    if (accept) begin
      pend_d = 1'b1;
      rej_d  = is_push & full;
      if (do_push) begin
        cnt_d = cnt_q + CNT_W'(1);
      end
    end
  end

  assign out_valid_d = retire | (out_valid_q & ~rsp_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rej_q <= rej_d;
    if (retire) begin
      found_q   <= enc_found;
      index_q   <= enc_index;
      count_q   <= cnt_q;
      rej_out_q <= rej_q;
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.found         = found_q;
  assign rsp_o.match_index   = index_q;
  assign rsp_o.entry_count   = count_q;
  assign rsp_o.push_rejected = rej_out_q;
  assign rsp_o.is_empty      = (count_q == '0);
  assign rsp_o.is_full       = (count_q == CNT_W'(CAPACITY));

endmodule

@@ sim/blps_list_checker.sv @@
// checker for the bounded list: watches both channels, predicts and compares responses
module blps_list_checker
  import blps_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  blps_req_if  req_i,
  blps_rsp_if  rsp_i,
  output int   err_count_o,
  output int   pending_o,
  output int   checked_o,
  output int   hits_o
);

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] match_index;
    logic [CNT_W-1:0] entry_count;
    logic             push_rejected;
    logic             is_empty;
    logic             is_full;
  } list_rsp_t;

  logic [WORD_W-1:0] stored_words [CAPACITY];
  int unsigned       stored_count;
  list_rsp_t         rsp_expected_q [$];
  list_rsp_t         want_rsp;
  list_rsp_t         next_rsp;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch on response %0d, %s: got %0d expected %0d", checked_o, what, got, want);
    err_count_o++;
  endtask

  // one request applied to the shadow list
  task automatic apply_request(input logic [REQ_W-1:0] kind, input logic [WORD_W-1:0] word,
                               output list_rsp_t r);
    int unsigned i;
    r = '0;
    case (kind)
      REQ_PUSH_BACK: begin
        if (stored_count >= CAPACITY) begin
          r.push_rejected = 1'b1;
        end else begin
          stored_words[stored_count] = word;
          stored_count++;
        end
      end
      REQ_PUSH_FRONT: begin
        if (stored_count >= CAPACITY) begin
          r.push_rejected = 1'b1;
        end else begin
          for (i = stored_count; i > 0; i--) stored_words[i] = stored_words[i-1];
          stored_words[0] = word;
          stored_count++;
        end
      end
      REQ_SEARCH: begin
        for (i = 0; i < stored_count; i++) begin
          if (!r.found && stored_words[i] == word) begin
            r.found       = 1'b1;
            r.match_index = IDX_W'(i);
          end
        end
      end
      default: ;
    endcase
    r.entry_count = CNT_W'(stored_count);
    r.is_empty    = (stored_count == 0);
    r.is_full     = (stored_count == CAPACITY);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stored_count = 0;
      rsp_expected_q.delete();
      err_count_o = 0;
      pending_o   = 0;
      checked_o   = 0;
      hits_o      = 0;
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        if (rsp_expected_q.size() == 0) begin
          report_mismatch("word with no request outstanding", 1, 0);
        end else begin
          want_rsp = rsp_expected_q.pop_front();
          if (rsp_i.found !== want_rsp.found)
            report_mismatch("found", rsp_i.found, want_rsp.found);
          if (rsp_i.match_index !== want_rsp.match_index)
            report_mismatch("match_index", rsp_i.match_index, want_rsp.match_index);
          if (rsp_i.entry_count !== want_rsp.entry_count)
            report_mismatch("entry_count", rsp_i.entry_count, want_rsp.entry_count);
          if (rsp_i.push_rejected !== want_rsp.push_rejected)
            report_mismatch("push_rejected", rsp_i.push_rejected, want_rsp.push_rejected);
          if (rsp_i.is_empty !== want_rsp.is_empty)
            report_mismatch("is_empty", rsp_i.is_empty, want_rsp.is_empty);
          if (rsp_i.is_full !== want_rsp.is_full)
            report_mismatch("is_full", rsp_i.is_full, want_rsp.is_full);
          if (want_rsp.found) hits_o++;
        end
        checked_o++;
      end
      if (req_i.valid && req_i.ready) begin
        apply_request(req_i.req_type, req_i.value, next_rsp);
        rsp_expected_q.insert(rsp_expected_q.size(), next_rsp);
      end
      pending_o = rsp_expected_q.size();
    end
  end

endmodule

@@ sim/bounded_list_push_and_search_tb.sv @@
// testbench top for the bounded list: clock, reset, request words, stalls and verdict
module bounded_list_push_and_search_tb;
  import blps_pkg::*;

  localparam logic [REQ_W-1:0]  REQ_UNUSED  = 2'd3;
  localparam logic [WORD_W-1:0] MARK_WORD   = -1000;
  localparam int                N_RANDOM    = 1800;
  localparam int                STALL_LIMIT = 2000;

  logic clk_i;
  logic rst_ni;

  int idle_pct = 28;
  int quiet_cycles;
  int err_count, pending, checked, hits;
  int n_back, n_front, n_search, n_unused;

  logic [WORD_W-1:0] pushed_words [$];

  blps_req_if req_if ();
  blps_rsp_if rsp_if ();

  bounded_list_push_and_search u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  blps_list_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_if),
    .rsp_i       (rsp_if),
    .err_count_o (err_count),
    .pending_o   (pending),
    .checked_o   (checked),
    .hits_o      (hits)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      rsp_if.ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
          $display("DONE: errors detected");
          $finish;
        end
      end
    end else begin
      quiet_cycles <= 0;
    end
  end

  // called and left at a falling edge; valid stays high between back-to-back words
  task automatic send_word(input logic [REQ_W-1:0] kind, input logic [WORD_W-1:0] word);
    while ($urandom_range(99) < idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid    <= 1'b1;
    req_if.req_type <= kind;
    req_if.value    <= word;
    do @(posedge clk_i); while (!req_if.ready);
    @(negedge clk_i);
    case (kind)
      REQ_PUSH_BACK: begin
        n_back++;
        if (pushed_words.size() < CAPACITY) pushed_words.insert(pushed_words.size(), word);
      end
      REQ_PUSH_FRONT: begin
        n_front++;
        if (pushed_words.size() < CAPACITY) pushed_words.insert(0, word);
      end
      REQ_SEARCH: n_search++;
      default:    n_unused++;
    endcase
  endtask

  function automatic logic [WORD_W-1:0] any_stored_word();
    if (pushed_words.size() == 0) return $urandom;
    return pushed_words[$urandom_range(pushed_words.size() - 1)];
  endfunction

  initial begin
    int pick;
    req_if.valid    = 1'b0;
    req_if.req_type = REQ_PUSH_BACK;
    req_if.value    = '0;
    rst_ni          = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // empty list, extremes, first match among duplicates
    send_word(REQ_SEARCH, '0);
    send_word(REQ_UNUSED, 32'hFFFF_FFFF);
    send_word(REQ_PUSH_BACK, 32'h7FFF_FFFF);
    send_word(REQ_PUSH_FRONT, 32'h8000_0000);
    send_word(REQ_SEARCH, 32'h8000_0000);
    send_word(REQ_SEARCH, 32'h7FFF_FFFF);
    send_word(REQ_SEARCH, '0);
    send_word(REQ_PUSH_BACK, MARK_WORD);
    send_word(REQ_PUSH_FRONT, 32'hFFFF_FFFF);
    send_word(REQ_PUSH_BACK, '0);
    send_word(REQ_PUSH_BACK, 32'h7FFF_FFFF);
    send_word(REQ_SEARCH, 32'h7FFF_FFFF);
    send_word(REQ_UNUSED, '0);
    // fill up to capacity
    while (pushed_words.size() < CAPACITY)
      send_word($urandom_range(1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK, $urandom);
    send_word(REQ_SEARCH, pushed_words[CAPACITY-1]);
    send_word(REQ_PUSH_BACK, 32'h1234_5678);
    send_word(REQ_PUSH_FRONT, 32'h8765_4321);
    send_word(REQ_UNUSED, 32'h5A5A_A5A5);
    send_word(REQ_SEARCH, MARK_WORD);

    for (int n = 0; n < N_RANDOM; n++) begin
      idle_pct = (n >= 700 && n < 1000) ? 0 : 28;
      pick = $urandom_range(99);
      if (pick < 55)
        send_word(REQ_SEARCH, any_stored_word());
      else if (pick < 70)
        send_word(REQ_SEARCH, any_stored_word() ^ (32'h1 << $urandom_range(WORD_W - 1)));
      else if (pick < 82)
        send_word(REQ_SEARCH, $urandom);
      else if (pick < 92)
        send_word($urandom_range(1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK, $urandom);
      else
        send_word(REQ_UNUSED, $urandom);
    end
    req_if.valid <= 1'b0;
    idle_pct = 28;

    wait (pending == 0);
    repeat (8) @(posedge clk_i);

    $display("sent %0d requests: %0d back pushes, %0d front pushes, %0d searches, %0d unused",
             n_back + n_front + n_search + n_unused, n_back, n_front, n_search, n_unused);
    $display("checked %0d responses, %0d searches hit a stored word", checked, hits);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ bounded_list_push_and_search.f @@
sv/blps_pkg.sv
sv/blps_if.sv
sv/blps_cell.sv
sv/blps_prio.sv
sv/bounded_list_push_and_search.sv
sim/blps_list_checker.sv
sim/bounded_list_push_and_search_tb.sv
